FILE: design/bbw_pkg.sv
// Shared types and constants of the box blur window block.
package bbw_pkg;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 12;
    localparam int RAD_CFG_W = 3;
    localparam int ROW_W     = 12;
    localparam int OCOL_W    = 11;
    localparam int CFG_IDX_W = 2;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [OCOL_W-1:0] t_ocol;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RADIUS = 2'd2
    } t_cfg_idx;

endpackage

FILE: design/bbw_if.sv
// Channel interfaces: pixel input, blurred result output, configuration writes.
interface bbw_pix_if;
    import bbw_pkg::*;
    logic valid;
    logic ready;
    t_pix pixel_in;
    logic frame_start;
    modport source (output valid, pixel_in, frame_start, input ready);
    modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface bbw_res_if;
    import bbw_pkg::*;
    logic  valid;
    logic  ready;
    t_pix  pixel_out;
    t_row  out_row;
    t_ocol out_col;
    logic  frame_last;
    modport source (output valid, pixel_out, out_row, out_col, frame_last, input ready);
    modport sink   (input valid, pixel_out, out_row, out_col, frame_last, output ready);
endinterface

interface bbw_cfg_if;
    import bbw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_dim                 data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/bbw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/bbw_mean.sv
// Window mean: window sum divided by the squared side through a reciprocal product.
module bbw_mean #(
    parameter int MAX_RADIUS = 7
) (
    input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*255+1)-1:0] i_sum,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]                            i_rad,
    output bbw_pkg::t_pix                                              o_mean
);
    import bbw_pkg::*;

    localparam int SUM_W  = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*255+1);
    localparam int PROD_W = SUM_W + 33;

    // ceil(2^32 / side^2): exact quotient for every sum this block can form
    logic [32:0] recip [0:MAX_RADIUS];

    for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
        localparam longint DIV = (2*g+1) * (2*g+1);
        localparam longint RCP = ((64'd1 << 32) + DIV - 1) / DIV;
        assign recip[g] = RCP[32:0];
    end

    logic [PROD_W-1:0] prod;

    assign prod   = PROD_W'(i_sum) * PROD_W'(recip[i_rad]);
    assign o_mean = prod[32 +: PIX_W];
endmodule

FILE: design/box_blur_window.sv
// Top level of the streaming box blur: sequencer, line store, column sums, window sum.
//
// Streaming box blur over an 8-bit grey raster. Each pixel runs a read-modify-write
// over two memories with registered reads: a line store of 2*MAX_RADIUS+1 rows used
// as a circular row buffer, and a store of running column sums, one per column. The
// pixel read out of the buffer slot is the one that left the vertical window, so a
// column sum is updated by one add and one subtract. A short shift line of recent
// column sums keeps the horizontal window sum running the same way. A transaction
// on the pixel input that yields no result runs a memory read, then update and
// write-back; one that yields a result adds a stage for the reciprocal multiply that
// forms the mean. The write-back comes before the next read of the same column. A
// pixel past the frame's last row or past the row width is dropped without leaving
// the idle state. Results are held in an output register, so the next pixel is taken
// while a result waits downstream; only when a second result is ready before the
// first is taken does the input stall. Results appear only for interior centres,
// with row, column and a last flag on the frame's final one. Memories need no
// clearing after reset. Configuration writes are always taken and must only be
// issued while the block is idle.
module box_blur_window #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 7
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bbw_pix_if.sink   i_pix,
    bbw_res_if.source o_res,
    bbw_cfg_if.sink   i_cfg
);
    import bbw_pkg::*;

    localparam int SPAN_ROWS = 2*MAX_RADIUS + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = $clog2(SPAN_ROWS);
    localparam int RADI_W    = $clog2(MAX_RADIUS + 1);
    localparam int LS_DEPTH  = SPAN_ROWS * MAX_WIDTH;
    localparam int LS_AW     = $clog2(LS_DEPTH);
    localparam int CS_W      = $clog2(SPAN_ROWS*255 + 1);
    localparam int WS_W      = $clog2(SPAN_ROWS*SPAN_ROWS*255 + 1);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV} t_state;

    // configuration
    t_dim                 r_cfg_w, r_cfg_h;
    logic [RAD_CFG_W-1:0] r_cfg_r;

    // effective geometry
    logic [COL_W:0]      w_eff;
    logic [RADI_W-1:0]   rad;
    logic [SLOT_W-1:0]   two_r;

    assign w_eff = (32'(r_cfg_w) > 32'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH)
                                                   : (COL_W+1)'(r_cfg_w);
    assign rad   = (32'(r_cfg_r) > 32'(MAX_RADIUS)) ? RADI_W'(MAX_RADIUS)
                                                    : RADI_W'(r_cfg_r);
    assign two_r = SLOT_W'({rad, 1'b0});

    // position counters and captured item
    t_state              r_state;
    t_row                r_row;
    logic [COL_W-1:0]    r_col;
    logic [SLOT_W-1:0]   r_slot;
    t_pix                r_pix;
    t_row                r_prow;
    logic [COL_W-1:0]    r_pcol;
    logic [LS_AW-1:0]    r_paddr;
    logic [WS_W-1:0]     r_win;
    logic [CS_W-1:0]     r_recent [0:SPAN_ROWS-1];
    t_row                r_orow;
    t_ocol               r_ocol;
    logic                r_olast;

    // output register
    logic  r_oval;
    t_pix  r_opix;
    t_row  r_res_row;
    t_ocol r_res_col;
    logic  r_res_last;

    // accept-side decode
    logic              accept;
    t_row              cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [SLOT_W-1:0] cur_slot;
    logic              live, in_row, row_end;
    logic [LS_AW-1:0]  rd_addr;

    assign accept   = i_pix.valid && i_pix.ready;
    assign cur_row  = i_pix.frame_start ? '0 : r_row;
    assign cur_col  = i_pix.frame_start ? '0 : r_col;
    assign cur_slot = i_pix.frame_start ? '0 : r_slot;
    assign live     = cur_row < r_cfg_h;
    assign in_row   = (COL_W+1)'(cur_col) < w_eff;
    assign row_end  = ((COL_W+1)'(cur_col) + (COL_W+1)'(1)) >= w_eff;
    assign rd_addr  = LS_AW'(cur_slot) * LS_AW'(MAX_WIDTH) + LS_AW'(cur_col);

    // memories
    t_pix            ls_rdata;
    logic [CS_W-1:0] cs_rdata;
    logic            calc;
    logic [CS_W-1:0] cs_new;
    logic [WS_W-1:0] win_new;
    logic            emit;
    t_pix            mean;

    assign calc = (r_state == S_CALC);

    bbw_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (calc),
        .i_waddr (r_paddr),
        .i_wdata (r_pix),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ls_rdata)
    );

    bbw_ram #(.WIDTH(CS_W), .DEPTH(MAX_WIDTH)) u_colsum_ram (
        .i_clk   (i_clk),
        .i_we    (calc),
        .i_waddr (r_pcol),
        .i_wdata (cs_new),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (cs_rdata)
    );

    bbw_mean #(.MAX_RADIUS(MAX_RADIUS)) u_mean (
        .i_sum  (r_win),
        .i_rad  (rad),
        .o_mean (mean)
    );

    // Column sum: drop the stale sum on the first row, subtract the pixel that
    // left the vertical window once the window is full.
    assign cs_new = ((r_prow == '0) ? '0 : cs_rdata) + CS_W'(r_pix)
                  - ((32'(r_prow) > 32'(two_r)) ? CS_W'(ls_rdata) : '0);

    // Window sum: restart at column zero, drop the column that left the window.
    assign win_new = ((r_pcol == '0) ? '0 : r_win) + WS_W'(cs_new)
                   - ((32'(r_pcol) > 32'(two_r)) ? WS_W'(r_recent[two_r]) : '0);

    assign emit = (32'(r_prow) >= 32'(two_r)) && (32'(r_pcol) >= 32'(two_r));

    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= t_dim'(640);
            r_cfg_h <= t_dim'(480);
            r_cfg_r <= RAD_CFG_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WIDTH:  r_cfg_w <= i_cfg.data;
                CFG_HEIGHT: r_cfg_h <= i_cfg.data;
                CFG_RADIUS: r_cfg_r <= i_cfg.data[RAD_CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
            r_win   <= '0;
            r_oval  <= 1'b0;
            for (int k = 0; k < SPAN_ROWS; k++) begin
                r_recent[k] <= '0;
            end
        end else begin
            // release the output register once the transaction completes;
            // the mean stage reloads it itself
            if (r_oval && o_res.ready && r_state != S_DIV) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pix   <= i_pix.pixel_in;
                        r_prow  <= cur_row;
                        r_pcol  <= cur_col;
                        r_paddr <= rd_addr;
                        if (live) begin
                            // advance raster position; rows past the frame are dropped
                            if (row_end) begin
                                r_col  <= '0;
                                r_row  <= cur_row + t_row'(1);
                                r_slot <= (cur_slot == two_r) ? '0
                                                              : cur_slot + SLOT_W'(1);
                            end else begin
                                r_col  <= cur_col + COL_W'(1);
                                r_row  <= cur_row;
                                r_slot <= cur_slot;
                            end
                            if (in_row) begin
                                r_state <= S_CALC;
                            end
                        end else begin
                            r_col  <= cur_col;
                            r_row  <= cur_row;
                            r_slot <= cur_slot;
                        end
                    end
                end
                S_CALC: begin
                    r_win       <= win_new;
                    r_recent[0] <= cs_new;
                    for (int k = 1; k < SPAN_ROWS; k++) begin
                        r_recent[k] <= r_recent[k-1];
                    end
                    r_orow  <= r_prow - t_row'(rad);
                    r_ocol  <= OCOL_W'(r_pcol - COL_W'(rad));
                    r_olast <= ((r_prow + t_row'(1)) == r_cfg_h)
                            && (((COL_W+1)'(r_pcol) + (COL_W+1)'(1)) == w_eff);
                    r_state <= emit ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    // hold until the output register is free
                    if (!r_oval || o_res.ready) begin
                        r_oval     <= 1'b1;
                        r_opix     <= mean;
                        r_res_row  <= r_orow;
                        r_res_col  <= r_ocol;
                        r_res_last <= r_olast;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_oval;
    assign o_res.pixel_out  = r_opix;
    assign o_res.out_row    = r_res_row;
    assign o_res.out_col    = r_res_col;
    assign o_res.frame_last = r_res_last;

    a_calc_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CALC |=> r_state != S_CALC)
        else $error("update stage held longer than one cycle");

    a_load_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_DIV))
        else $error("result loaded outside the mean stage");

    a_div_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && (!o_res.valid || o_res.ready)) |=> o_res.valid)
        else $error("mean stage did not load a free output register");
endmodule

FILE: verif/bbw_checker.sv
// Checker for the box blur window: predicts blurred results and compares them.
module bbw_checker
    import bbw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bbw_pix_if   pix,
    bbw_res_if   res,
    bbw_cfg_if   cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH_CAP  = 2048;
    localparam int RADIUS_CAP = 7;
    localparam int SPAN       = 2 * RADIUS_CAP;

    typedef struct packed {
        t_pix  mean;
        t_row  row;
        t_ocol col;
        logic  last;
    } blur_res_t;

    blur_res_t   blur_q[$];

    int unsigned width_reg, height_reg, radius_reg;
    logic [7:0]  row_hist [SPAN][WIDTH_CAP];
    int unsigned col_sum [WIDTH_CAP];
    int unsigned recent_sum [SPAN];
    int unsigned win_sum, row_cnt, col_cnt;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = blur_q.size();

    // Advance the blur state by one pixel and queue the mean it yields.
    function automatic void blur_step(input t_pix p, input logic fs);
        int unsigned w, h, rad, two_r, side, r, c, csum;
        blur_res_t   e;
        w     = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
        h     = height_reg;
        rad   = (radius_reg > RADIUS_CAP) ? RADIUS_CAP : radius_reg;
        two_r = 2 * rad;
        side  = two_r + 1;
        if (fs) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt;
        if (r >= h) return;
        if (c < w) begin
            csum = p;
            for (int k = 0; k < two_r; k++) csum += row_hist[k][c];
            col_sum[c] = csum;
            for (int k = SPAN - 1; k > 0; k--) row_hist[k][c] = row_hist[k-1][c];
            row_hist[0][c] = p;
            win_sum = csum;
            for (int k = 0; k < two_r; k++) win_sum += recent_sum[k];
            for (int k = SPAN - 1; k > 0; k--) recent_sum[k] = recent_sum[k-1];
            recent_sum[0] = csum;
            if (r >= two_r && c >= two_r) begin
                e.mean = t_pix'(win_sum / (side * side));
                e.row  = t_row'(r - rad);
                e.col  = t_ocol'(c - rad);
                e.last = (r + 1 == h) && (c + 1 == w);
                blur_q.push_back(e);
            end
        end
        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        blur_res_t got, want;
        if (!i_rst_n) begin
            width_reg  = 640;
            height_reg = 480;
            radius_reg = 1;
            foreach (row_hist[k, c]) row_hist[k][c] = '0;
            foreach (col_sum[c]) col_sum[c] = 0;
            foreach (recent_sum[k]) recent_sum[k] = 0;
            win_sum = 0;
            row_cnt = 0;
            col_cnt = 0;
            fails   = 0;
            blur_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (t_cfg_idx'(cfg.index))
                    CFG_WIDTH:  width_reg  = cfg.data;
                    CFG_HEIGHT: height_reg = cfg.data;
                    CFG_RADIUS: radius_reg = cfg.data[RAD_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) blur_step(pix.pixel_in, pix.frame_start);
            if (res.valid && res.ready) begin
                got = '{res.pixel_out, res.out_row, res.out_col, res.frame_last};
                if (blur_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fails++;
                end else begin
                    want = blur_q.pop_front();
                    if (got.mean != want.mean) begin
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, want.mean, got.mean);
                        fails++;
                    end
                    if (got.row != want.row) begin
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, want.row, got.row);
                        fails++;
                    end
                    if (got.col != want.col) begin
                        $display("%0t: out_col expected %0d actual %0d",
                                 $time, want.col, got.col);
                        fails++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: frame_last expected %0d actual %0d",
                                 $time, want.last, got.last);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb_top.sv
// Top of the box blur window testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bbw_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 10;
    localparam int RAND_ITEMS  = 400;
    localparam int QUIET_AFTER = 320;

    // Pixel value patterns for a run of pixels.
    typedef enum int { PAT_RANDOM, PAT_WHITE, PAT_BLACK } t_pattern;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending;
    int   idle_cycles;
    int   rand_sent;
    bit   counting;
    bit   no_idle;
    int   stall_left;

    bbw_pix_if pix_ch();
    bbw_res_if res_ch();
    bbw_cfg_if cfg_ch();

    box_blur_window dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    bbw_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .pix         (pix_ch),
        .res         (res_ch),
        .cfg         (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver back-pressure: drop ready in random bursts.
    always @(negedge i_clk) begin
        if (no_idle || !i_rst_n) begin
            stall_left   <= 0;
            res_ch.ready <= i_rst_n;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 3);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** box_blur_window: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write one configuration register and hold until the transaction completes;
    // valid stays high so consecutive writes follow back to back.
    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= t_dim'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // Send one pixel; valid stays high afterwards so back-to-back pixels stream.
    task automatic send_pixel(input t_pix p, input logic fs);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_in    <= p;
        pix_ch.frame_start <= fs;
        do @(posedge i_clk); while (!pix_ch.ready);
        @(negedge i_clk);
        if (counting) rand_sent++;
        if (rand_sent > QUIET_AFTER) no_idle = 1'b1;
    endtask

    // Send a run of n pixels starting a frame, then some past its end.
    // Noise adds stray frame starts that restart the counters mid-frame.
    task automatic send_frame(input int n, input t_pattern pat, input int extra,
                              input bit noise);
        t_pix p;
        logic fs;
        for (int i = 0; i < n + extra; i++) begin
            case (pat)
                PAT_WHITE: p = 8'hFF;
                PAT_BLACK: p = 8'h00;
                default:   p = t_pix'($urandom);
            endcase
            fs = (i == 0) || (noise && i < n && $urandom_range(0, 199) == 0);
            send_pixel(p, fs);
        end
    endtask

    // Hold off the sender until every result is in, then let the pipe settle.
    task automatic drain;
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned r);
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_RADIUS, r);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int w, h, r, n;
        // Drive every input to a known value before the first edge.
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_in    = '0;
        pix_ch.frame_start = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_WIDTH;
        cfg_ch.data        = '0;
        counting    = 1'b0;
        no_idle     = 1'b0;
        rand_sent   = 0;
        i_rst_n     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: smallest full windows at the value extremes.
        set_frame(3, 3, 1);
        send_frame(9, PAT_WHITE, 0, 0);
        send_frame(9, PAT_BLACK, 2, 0);
        // Single pixel frame with no averaging.
        set_frame(1, 1, 0);
        send_frame(1, PAT_WHITE, 1, 0);
        // Width zero: every pixel is its own row, nothing comes out.
        set_frame(0, 5, 1);
        send_frame(4, PAT_RANDOM, 0, 0);
        // Height zero ignores everything.
        set_frame(4, 0, 1);
        send_frame(4, PAT_RANDOM, 0, 0);
        // Frame too small for the window.
        set_frame(4, 6, 2);
        send_frame(24, PAT_RANDOM, 0, 0);
        // Largest radius with the smallest frame that still fits it.
        set_frame(15, 15, 7);
        send_frame(225, PAT_WHITE, 0, 0);
        // Oversized width saturates to the line store size.
        set_frame(4095, 1, 0);
        send_frame(2048, PAT_RANDOM, 1, 0);
        // Tallest frame, left unfinished and restarted by the next frame start.
        set_frame(5, 4095, 2);
        send_frame(40, PAT_RANDOM, 0, 0);

        // Random phases of well-formed frames with some noise.
        counting = 1'b1;
        while (rand_sent < RAND_ITEMS) begin
            r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20);
            h = $urandom_range(1, 16);
            set_frame(w, h, r);
            repeat ($urandom_range(1, 3)) begin
                n = w * h;
                if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
                send_frame(n, PAT_RANDOM,
                           (n == w * h) ? $urandom_range(0, 3) : 0,
                           $urandom_range(0, 3) == 0);
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("** box_blur_window: PASSED **");
        end else begin
            $display("** box_blur_window: FAILED **");
        end
        $finish;
    end
endmodule
